// ===== rtl/ihrc_pkg.sv =====
// Shared types and constants for the IPv4 header receive check.
// Used by the register port, the header check datapath and the top level; no dependencies.
package ihrc_pkg;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ADDR_W  = 32;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned SUM_W   = 21;
  localparam int unsigned IHL_W   = 4;
  localparam int unsigned PADDR_W = 3;

  localparam logic [IHL_W-1:0]   MIN_IHL     = 4'd5;
  localparam logic [COUNT_W-1:0] SHORT_SPAN  = 5'd10;

  localparam logic [COUNT_W-1:0] IDX_FIRST    = 5'd0;
  localparam logic [COUNT_W-1:0] IDX_TOTAL    = 5'd1;
  localparam logic [COUNT_W-1:0] IDX_PROTOCOL = 5'd4;
  localparam logic [COUNT_W-1:0] IDX_CHECKSUM = 5'd5;
  localparam logic [COUNT_W-1:0] IDX_SRC_HI   = 5'd6;
  localparam logic [COUNT_W-1:0] IDX_SRC_LO   = 5'd7;
  localparam logic [COUNT_W-1:0] IDX_DST_HI   = 5'd8;
  localparam logic [COUNT_W-1:0] IDX_DST_LO   = 5'd9;
  localparam logic [COUNT_W-1:0] MAX_IDX      = 5'd29;

  localparam logic PREG_OUR_ADDRESS = 1'b0;

  typedef enum logic [1:0] {
    STATUS_ACCEPTED  = 2'd0,
    STATUS_WRONG_DST = 2'd1,
    STATUS_BAD_SUM   = 2'd2,
    STATUS_MALFORMED = 2'd3
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [WORD_W-1:0]   data_length;
    logic [ADDR_W-1:0]   source_address;
    logic [7:0]          protocol_number;
    logic [COUNT_W-1:0]  header_words;
  } result_t;

endpackage

// ===== rtl/ihrc_cfg_regs.sv =====
// APB-style register port holding the local IPv4 address.
// Depends on ihrc_pkg for the address width and register decode.
module ihrc_cfg_regs
  import ihrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output logic [ADDR_W-1:0]  our_address
);

  logic reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == PREG_OUR_ADDRESS);
  assign prdata  = reg_sel ? our_address : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      our_address <= '0;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      our_address <= pwdata;
    end
  end

endmodule

// ===== rtl/ihrc_hdr_check.sv =====
// Input word register, per-header state and verdict register.
// Depends on ihrc_pkg for field widths, word positions and the result type.
module ihrc_hdr_check
  import ihrc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic [ADDR_W-1:0] our_address,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [WORD_W-1:0] header_word,
  output logic              out_valid,
  input  logic              out_stall,
  output result_t           result
);

  logic               word_valid;
  logic [WORD_W-1:0]  word_q;

  logic [COUNT_W-1:0] word_count;
  logic [SUM_W-1:0]   running_sum;
  logic [IHL_W-1:0]   header_length;
  logic [WORD_W-1:0]  total_length;
  logic [7:0]         protocol_seen;
  logic [ADDR_W-1:0]  source_seen;
  logic               destination_matches;
  logic [WORD_W-1:0]  checksum_seen;

  logic [IHL_W-1:0]   hl_eff;
  logic [COUNT_W-1:0] span;
  logic               last;
  logic               advance;
  logic               load;
  logic [SUM_W-1:0]   sum_eff;
  logic               dst_eff;
  logic [16:0]        fold1;
  logic [WORD_W-1:0]  fold2;
  logic [WORD_W-1:0]  hdr_bytes;
  logic               malformed;
  result_t            verdict;

  assign hl_eff  = (word_count == IDX_FIRST) ? word_q[11:8] : header_length;
  assign span    = (hl_eff < MIN_IHL) ? SHORT_SPAN : {hl_eff, 1'b0};
  assign last    = ({1'b0, word_count} + 6'd1) >= {1'b0, span};
  assign advance = word_valid && (!last || !out_valid || !out_stall);
  assign load    = advance && last;
  assign in_stall = word_valid && !advance;

  assign sum_eff = running_sum +
                   ((word_count != IDX_CHECKSUM) ? {5'd0, word_q} : '0);
  assign dst_eff = destination_matches &&
                   !((word_count == IDX_DST_HI) && (word_q != our_address[31:16])) &&
                   !((word_count == IDX_DST_LO) && (word_q != our_address[15:0]));

  assign fold1     = {1'b0, sum_eff[15:0]} + {12'd0, sum_eff[20:16]};
  assign fold2     = fold1[15:0] + {15'd0, fold1[16]};
  assign hdr_bytes = {10'd0, hl_eff, 2'b00};
  assign malformed = (hl_eff < MIN_IHL) || (total_length < hdr_bytes);

  always_comb begin
    verdict.data_length     = malformed ? '0 : (total_length - hdr_bytes);
    verdict.source_address  = source_seen;
    verdict.protocol_number = protocol_seen;
    verdict.header_words    = span;
    priority if (malformed) begin
      verdict.status = STATUS_MALFORMED;
    end else if (!dst_eff) begin
      verdict.status = STATUS_WRONG_DST;
    end else if (~fold2 != checksum_seen) begin
      verdict.status = STATUS_BAD_SUM;
    end else begin
      verdict.status = STATUS_ACCEPTED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      word_valid <= 1'b1;
    end else if (advance) begin
      word_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      word_q <= header_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || load) begin
      word_count          <= '0;
      running_sum         <= '0;
      header_length       <= '0;
      total_length        <= '0;
      protocol_seen       <= '0;
      source_seen         <= '0;
      destination_matches <= 1'b1;
      checksum_seen       <= '0;
    end else if (advance) begin
      word_count          <= word_count + 5'd1;
      running_sum         <= sum_eff;
      header_length       <= hl_eff;
      destination_matches <= dst_eff;
      if (word_count == IDX_TOTAL) begin
        total_length <= word_q;
      end
      if (word_count == IDX_PROTOCOL) begin
        protocol_seen <= word_q[7:0];
      end
      if (word_count == IDX_CHECKSUM) begin
        checksum_seen <= word_q;
      end
      if (word_count == IDX_SRC_HI) begin
        source_seen[31:16] <= word_q;
      end
      if (word_count == IDX_SRC_LO) begin
        source_seen[15:0] <= word_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result <= verdict;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    word_count <= MAX_IDX)
    else $error("word count ran past the longest header");

  a_clear_after_verdict: assert property (@(posedge clk) disable iff (rst)
    load |=> (word_count == '0) && destination_matches && (running_sum == '0))
    else $error("header state not cleared after a verdict");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> word_valid && last && out_valid && out_stall)
    else $error("input stalled without a held verdict");

  a_span_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (result.header_words >= SHORT_SPAN) && !result.header_words[0])
    else $error("verdict carries an impossible header word count");
`endif

endmodule

// ===== rtl/ip_header_receive_check.sv =====
// Top level of the IPv4 header receive check; instantiates the register port
// and the header check datapath. Depends on ihrc_pkg.
//
// The block takes one 16-bit header word per cycle while in_stall is low, in network
// byte order, and gives one verdict per header, with no gaps needed between
// headers. A word is held in an input register and from there updates the header
// state; the verdict is registered in the output register once the last header
// word has left the input register. in_stall rises only when the last word of a
// header is waiting while the previous verdict is still held by out_stall. The
// folded checksum, destination compare and length checks sit between the input
// word register and the verdict register. There is no clearing pass after reset.
module ip_header_receive_check_core
  import ihrc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [WORD_W-1:0]  header_word,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic [WORD_W-1:0]  data_length,
  output logic [ADDR_W-1:0]  source_address,
  output logic [7:0]         protocol_number,
  output logic [COUNT_W-1:0] header_words
);

  logic [ADDR_W-1:0] our_address;
  result_t           result;

  ihrc_cfg_regs u_cfg (
    .clk         (clk),
    .rst         (rst),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .our_address (our_address)
  );

  ihrc_hdr_check u_check (
    .clk         (clk),
    .rst         (rst),
    .our_address (our_address),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .header_word (header_word),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .result      (result)
  );

  assign status          = result.status;
  assign data_length     = result.data_length;
  assign source_address  = result.source_address;
  assign protocol_number = result.protocol_number;
  assign header_words    = result.header_words;

endmodule
